FILE: sv/bps_pkg.sv
// Shared widths, item codes and types for the byte pattern search block.
`default_nettype none

package bps_pkg;

	localparam int DATA_W = 8;
	localparam int POS_W = 5;
	localparam int LEN_W = 6;
	localparam int OFFSET_W = 32;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_HAYSTACK = 1'b1;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [OFFSET_W-1:0] offset_t;

	typedef struct packed {
		logic shift;
		logic active;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/bps_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface bps_item_if
	import bps_pkg::*;
();
	logic valid;
	logic ready;
	logic mode;
	data_t data_byte;
	pos_t needle_position;
	logic final_byte;

	modport source (output valid, mode, data_byte, needle_position, final_byte, input ready);
	modport sink (input valid, mode, data_byte, needle_position, final_byte, output ready);
endinterface

interface bps_result_if
	import bps_pkg::*;
();
	logic valid;
	logic ready;
	logic found;
	offset_t match_offset;

	modport source (output valid, found, match_offset, input ready);
	modport sink (input valid, found, match_offset, output ready);
endinterface

`default_nettype wire

FILE: sv/bps_cell.sv
// One window cell: holds a haystack byte and its aligned needle byte and compares them.
`default_nettype none

module bps_cell
	import bps_pkg::*;
(
	input  wire        clk,
	input  cell_ctrl_t ctrl,
	input  data_t      byte_in,
	input  data_t      aligned_d,
	output data_t      byte_out,
	output logic       hit
);

	data_t window_q;
	data_t aligned_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			window_q <= byte_in;
		end
		aligned_q <= aligned_d;
	end

	assign byte_out = window_q;
	assign hit = !ctrl.active || (window_q == aligned_q);

endmodule

`default_nettype wire

FILE: sv/byte_pattern_search.sv
// Top level of the byte pattern search block: needle store, cell chain and result stage.
//
// Finds the first occurrence of a needle of up to NEEDLE_MAX bytes in a haystack byte
// stream. A transaction with mode 0 writes one needle byte at needle_position; one with
// mode 1 shifts a haystack byte into a chain of NEEDLE_MAX cells, each of which compares
// its byte with the needle byte aligned to it for the current needle length. The block
// takes one transaction per cycle unless a result waits for the output register. The window
// shift is registered in the cells; compare, length check and offset subtraction feed the
// result register. The first full match gives found = 1 with the offset of the match start,
// later bytes up to the final byte give nothing; with no match the final byte gives found = 0.
// A zero needle length matches at offset 0. The needle length is written through cfg_we and
// cfg_data; the user must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module byte_pattern_search
	import bps_pkg::*;
#(
	parameter int NEEDLE_MAX = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	bps_item_if.sink          items,
	bps_result_if.source      results,
	input  wire               cfg_we,
	input  wire [LEN_W-1:0]   cfg_data
);

	localparam int EW = $clog2(NEEDLE_MAX + 1);
	localparam int VW = NEEDLE_MAX * DATA_W;

	logic [VW-1:0] needle_q;
	logic [VW-1:0] needle_d;
	logic [VW-1:0] reversed_d;
	logic [VW-1:0] aligned_vec;
	len_t len_q;
	len_t len_d;
	logic [EW-1:0] len_eff_d;
	logic [EW-1:0] len_eff;
	logic [EW-1:0] len_gap;
	logic [EW+2:0] shift_amt;

	logic valid_s1;
	logic last_s1;
	offset_t bytes_seen_q;
	logic new_search_q;
	logic match_reported_q;

	logic out_valid_q;
	logic found_q;
	offset_t offset_q;

	logic accept;
	logic load_acc;
	logic hay_acc;
	logic advance;
	logic out_free;
	logic all_hit;
	logic zero_len;
	logic full_match;
	logic res_valid;
	offset_t res_offset;

	data_t chain [NEEDLE_MAX+1];
	logic [NEEDLE_MAX-1:0] hits;

	assign accept = items.valid && items.ready;
	assign load_acc = accept && (items.mode == MODE_LOAD);
	assign hay_acc = accept && (items.mode == MODE_HAYSTACK);

	// Needle store and the next-state needle seen by the aligned copies in the cells.
	for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_needle
		assign needle_d[k*DATA_W +: DATA_W] =
			(load_acc && (32'(items.needle_position) == k)) ?
			items.data_byte : needle_q[k*DATA_W +: DATA_W];
		assign reversed_d[k*DATA_W +: DATA_W] =
			needle_d[(NEEDLE_MAX-1-k)*DATA_W +: DATA_W];
	end

	assign len_d = cfg_we ? cfg_data : len_q;
	assign len_eff_d = (32'(len_d) > 32'(NEEDLE_MAX)) ? EW'(NEEDLE_MAX) : EW'(len_d);
	assign len_eff = (32'(len_q) > 32'(NEEDLE_MAX)) ? EW'(NEEDLE_MAX) : EW'(len_q);
	assign len_gap = EW'(NEEDLE_MAX) - len_eff_d;
	assign shift_amt = {len_gap, 3'b000};
	assign aligned_vec = reversed_d >> shift_amt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q <= '0;
			len_q <= '0;
		end else begin
			needle_q <= needle_d;
			len_q <= len_d;
		end
	end

	// Window chain: cell k holds the haystack byte seen k bytes ago.
	assign chain[0] = items.data_byte;
	for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
		cell_ctrl_t ctrl;
		assign ctrl.shift = hay_acc;
		assign ctrl.active = (32'(k) < 32'(len_eff));
		bps_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.byte_in   (chain[k]),
			.aligned_d (aligned_vec[k*DATA_W +: DATA_W]),
			.byte_out  (chain[k+1]),
			.hit       (hits[k])
		);
	end

	assign all_hit = &hits;
	assign zero_len = (len_eff == '0);
	assign full_match = zero_len || ((bytes_seen_q >= OFFSET_W'(len_eff)) && all_hit);
	assign res_valid = valid_s1 && !match_reported_q && (full_match || last_s1);
	assign res_offset = zero_len ? '0 : (bytes_seen_q - OFFSET_W'(len_eff));

	assign out_free = !out_valid_q || results.ready;
	assign advance = !valid_s1 || !res_valid || out_free;
	assign items.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			bytes_seen_q <= '0;
			new_search_q <= 1'b1;
			match_reported_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= hay_acc;
				if (valid_s1) begin
					if (last_s1) begin
						match_reported_q <= 1'b0;
					end else if (res_valid) begin
						match_reported_q <= 1'b1;
					end
				end
			end
			if (hay_acc) begin
				last_s1 <= items.final_byte;
				new_search_q <= items.final_byte;
				if (new_search_q) begin
					bytes_seen_q <= OFFSET_W'(1);
				end else if (bytes_seen_q != '1) begin
					bytes_seen_q <= bytes_seen_q + OFFSET_W'(1);
				end
			end
			if (out_free) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			found_q <= full_match;
			offset_q <= full_match ? res_offset : '0;
		end
	end

	assign results.valid = out_valid_q;
	assign results.found = found_q;
	assign results.match_offset = offset_q;

endmodule

`default_nettype wire
